/* rtl/core/tmre_pkg.sv */
`default_nettype none

package tmre_pkg;

    // Entry layout: tile [8:0], palette [12:9], bit 13 zero, vflip [14], hflip [15]
    localparam int ENTRY_W    = 16;
    localparam int TILE_W     = 9;
    localparam int PAL_W      = 4;
    localparam int PAL_LSB    = 9;
    localparam int VFLIP_BIT  = 14;
    localparam int HFLIP_BIT  = 15;

    // Command field widths, sized for the largest supported map and plane count
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int PLANE_W    = 2;

    localparam logic [ENTRY_W-1:0] PAL_KEEP_MASK = 16'hE1FF;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_FILL    = 2'd2,
        OP_RECOLOR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ
    } t_back_state;

    // Decoded command: coordinates already wrapped, sizes already saturated
    typedef struct packed {
        t_op                op;
        logic [PLANE_W-1:0] plane;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic [ENTRY_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/core/tmre_front.sv */
`default_nettype none

module tmre_front #(
    parameter int MAP_WIDTH   = 32,
    parameter int MAP_HEIGHT  = 32,
    parameter int PLANE_COUNT = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [1:0]           i_opcode,
    input  wire logic                 i_plane,
    input  wire logic [4:0]           i_pos_x,
    input  wire logic [4:0]           i_pos_y,
    input  wire logic [5:0]           i_rect_width,
    input  wire logic [5:0]           i_rect_height,
    input  wire logic [8:0]           i_tile_number,
    input  wire logic [3:0]           i_palette,
    input  wire logic                 i_flip_h,
    input  wire logic                 i_flip_v,
    input  wire logic                 i_clearing,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output tmre_pkg::t_cmd            o_cmd
);

    logic           r_valid;
    logic           n_valid;
    tmre_pkg::t_cmd r_cmd;
    tmre_pkg::t_cmd n_cmd;
    logic           accept;

    assign o_push = r_valid && !i_q_full;
    assign o_busy = i_clearing || (r_valid && i_q_full);
    assign accept = i_start && !o_busy;
    assign o_cmd  = r_cmd;

    always_comb begin
        logic [tmre_pkg::POS_W-1:0] x;
        logic [tmre_pkg::POS_W-1:0] y;
        x = {1'b0, i_pos_x};
        y = {1'b0, i_pos_y};
        // position < 32 and map side >= 8: three subtract steps cover it
        for (int k = 0; k < 3; k++) begin
            if (int'(x) >= MAP_WIDTH) begin
                x = x - tmre_pkg::POS_W'(MAP_WIDTH);
            end
            if (int'(y) >= MAP_HEIGHT) begin
                y = y - tmre_pkg::POS_W'(MAP_HEIGHT);
            end
        end

        n_cmd.op    = tmre_pkg::t_op'(i_opcode);
        n_cmd.plane = (int'(i_plane) >= PLANE_COUNT) ?
                      tmre_pkg::PLANE_W'(PLANE_COUNT - 1) : {1'b0, i_plane};
        n_cmd.x     = x;
        n_cmd.y     = y;
        n_cmd.cols  = (int'(i_rect_width) > MAP_WIDTH) ?
                      tmre_pkg::CNT_W'(MAP_WIDTH) : {1'b0, i_rect_width};
        n_cmd.rows  = (int'(i_rect_height) > MAP_HEIGHT) ?
                      tmre_pkg::CNT_W'(MAP_HEIGHT) : {1'b0, i_rect_height};

        unique case (tmre_pkg::t_op'(i_opcode))
            tmre_pkg::OP_WRITE: begin
                n_cmd.value = {i_flip_h, i_flip_v, 1'b0, i_palette, i_tile_number};
            end
            tmre_pkg::OP_FILL: begin
                n_cmd.value = {3'b000, i_palette, i_tile_number};
            end
            tmre_pkg::OP_RECOLOR: begin
                n_cmd.value = {3'b000, i_palette, 9'd0};
            end
            default: begin
                n_cmd.value = '0;
            end
        endcase

        n_valid = r_valid && !o_push;
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tmre_queue.sv */
`default_nettype none

module tmre_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tmre_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tmre_pkg::t_cmd      o_cmd
);

    tmre_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

/* rtl/core/tmre_back.sv */
`default_nettype none

module tmre_back #(
    parameter int MAP_WIDTH   = 32,
    parameter int MAP_HEIGHT  = 32,
    parameter int PLANE_COUNT = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire tmre_pkg::t_cmd i_q_cmd,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_strobe,
    output logic [8:0]          o_read_tile,
    output logic [3:0]          o_read_palette
);

    localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int DEPTH  = PLANE_COUNT * CELLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int EW = tmre_pkg::ENTRY_W;
    localparam int PW = tmre_pkg::POS_W;
    localparam int CW = tmre_pkg::CNT_W;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [tmre_pkg::PLANE_W-1:0] p,
        input logic [PW-1:0]                x,
        input logic [PW-1:0]                y
    );
        cell_addr = ADDR_W'(int'(p) * CELLS + int'(y) * MAP_WIDTH + int'(x));
    endfunction

    logic [EW-1:0] mem [DEPTH];

    tmre_pkg::t_back_state r_state,    n_state;
    tmre_pkg::t_cmd        r_cmd,      n_cmd;
    logic [ADDR_W-1:0]     r_clr,      n_clr;
    logic [PW-1:0]         r_cx,       n_cx;
    logic [PW-1:0]         r_cy,       n_cy;
    logic [CW-1:0]         r_col,      n_col;
    logic [CW-1:0]         r_row,      n_row;
    logic                  r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0]     r_wb_addr,  n_wb_addr;
    logic                  r_strobe,   n_strobe;
    logic [8:0]            r_tile,     n_tile;
    logic [3:0]            r_pal,      n_pal;
    logic [EW-1:0]         r_rdata;

    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [EW-1:0]         wdata;
    logic [ADDR_W-1:0]     raddr;
    logic [ADDR_W-1:0]     walk_addr;
    logic                  last_col;
    logic                  last_row;

    assign o_clearing     = (r_state == tmre_pkg::ST_CLEAR);
    assign o_strobe       = r_strobe;
    assign o_read_tile    = r_tile;
    assign o_read_palette = r_pal;

    assign walk_addr = cell_addr(r_cmd.plane, r_cx, r_cy);
    assign last_col  = (r_col == r_cmd.cols - CW'(1));
    assign last_row  = (r_row == r_cmd.rows - CW'(1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_clr      = r_clr;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_col      = r_col;
        n_row      = r_row;
        n_wb_valid = 1'b0;
        n_wb_addr  = r_wb_addr;
        n_strobe   = 1'b0;
        n_tile     = '0;
        n_pal      = '0;
        o_pop      = 1'b0;
        we         = 1'b0;
        waddr      = walk_addr;
        wdata      = r_cmd.value;
        raddr      = walk_addr;

        // recolor write-back, in the cycle after its read
        if (r_wb_valid) begin
            we    = 1'b1;
            waddr = r_wb_addr;
            wdata = (r_rdata & tmre_pkg::PAL_KEEP_MASK) | r_cmd.value;
        end

        unique case (r_state)
            tmre_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = tmre_pkg::ST_IDLE;
                end
            end
            tmre_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_cmd;
                    n_cx  = i_q_cmd.x;
                    n_cy  = i_q_cmd.y;
                    n_col = '0;
                    n_row = '0;
                    raddr = cell_addr(i_q_cmd.plane, i_q_cmd.x, i_q_cmd.y);
                    unique case (i_q_cmd.op)
                        tmre_pkg::OP_WRITE: begin
                            we       = 1'b1;
                            waddr    = raddr;
                            wdata    = i_q_cmd.value;
                            n_strobe = 1'b1;
                        end
                        tmre_pkg::OP_READ: begin
                            n_state = tmre_pkg::ST_READ;
                        end
                        tmre_pkg::OP_FILL, tmre_pkg::OP_RECOLOR: begin
                            if (i_q_cmd.cols == '0 || i_q_cmd.rows == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = tmre_pkg::ST_WALK;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            tmre_pkg::ST_WALK: begin
                if (r_cmd.op == tmre_pkg::OP_RECOLOR) begin
                    n_wb_valid = 1'b1;
                    n_wb_addr  = walk_addr;
                end else begin
                    we    = 1'b1;
                    waddr = walk_addr;
                    wdata = r_cmd.value;
                end
                if (last_col) begin
                    n_col = '0;
                    n_cx  = r_cmd.x;
                    n_row = r_row + CW'(1);
                    n_cy  = (int'(r_cy) == MAP_HEIGHT - 1) ? '0 : r_cy + PW'(1);
                    if (last_row) begin
                        if (r_cmd.op == tmre_pkg::OP_RECOLOR) begin
                            n_state = tmre_pkg::ST_DRAIN;
                        end else begin
                            n_strobe = 1'b1;
                            n_state  = tmre_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    n_col = r_col + CW'(1);
                    n_cx  = (int'(r_cx) == MAP_WIDTH - 1) ? '0 : r_cx + PW'(1);
                end
            end
            tmre_pkg::ST_DRAIN: begin
                n_strobe = 1'b1;
                n_state  = tmre_pkg::ST_IDLE;
            end
            tmre_pkg::ST_READ: begin
                n_strobe = 1'b1;
                n_tile   = r_rdata[tmre_pkg::TILE_W-1:0];
                n_pal    = r_rdata[tmre_pkg::PAL_LSB +: tmre_pkg::PAL_W];
                n_state  = tmre_pkg::ST_IDLE;
            end
            default: begin
                n_state = tmre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmre_pkg::ST_CLEAR;
            r_clr      <= '0;
            r_wb_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_wb_valid <= n_wb_valid;
            r_strobe   <= n_strobe;
        end
        r_cmd     <= n_cmd;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_col     <= n_col;
        r_row     <= n_row;
        r_wb_addr <= n_wb_addr;
        r_tile    <= n_tile;
        r_pal     <= n_pal;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmre_pkg::ST_CLEAR) |=> !r_strobe)
        else $error("result during clearing pass");
    a_wb_in_recolor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> ((r_state == tmre_pkg::ST_WALK || r_state == tmre_pkg::ST_DRAIN)
                        && r_cmd.op == tmre_pkg::OP_RECOLOR))
        else $error("write-back outside a recolor walk");
`endif

endmodule

`default_nettype wire

/* rtl/core/tile_map_rect_engine.sv */
// Channel   Handshake              Fields
// -------   --------------------   ---------------------------------------------
// command   start / busy           opcode plane pos_x pos_y rect_width rect_height
//                                  tile_number palette flip_h flip_v
// result    o_result_strobe        read_tile read_palette (zero unless a read)
//
// A command transfers at an edge with start high and busy low; behind the map sequencer
// one can wait in the decode register and two more in the queue.
// Sequencer steps: a write or empty rectangle finishes in idle, a read passes the read
// state, and fill and recolor walk cols*rows entries, one entry per cycle (set by the
// single map memory write port); a recolor then drains. Each result is registered.
// After reset a clearing pass zeroes PLANE_COUNT*MAP_WIDTH*MAP_HEIGHT entries,
// one per cycle (2048 by default), with busy held high.
// Each result shows for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module tile_map_rect_engine #(
    parameter int MAP_WIDTH   = 32,
    parameter int MAP_HEIGHT  = 32,
    parameter int PLANE_COUNT = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic       i_plane,
    input  wire logic [4:0] i_pos_x,
    input  wire logic [4:0] i_pos_y,
    input  wire logic [5:0] i_rect_width,
    input  wire logic [5:0] i_rect_height,
    input  wire logic [8:0] i_tile_number,
    input  wire logic [3:0] i_palette,
    input  wire logic       i_flip_h,
    input  wire logic       i_flip_v,
    output logic            o_result_strobe,
    output logic [8:0]      o_read_tile,
    output logic [3:0]      o_read_palette
);

    // front -> queue
    logic           push;
    tmre_pkg::t_cmd front_cmd;
    logic           q_full;
    // queue -> back
    logic           q_valid;
    tmre_pkg::t_cmd q_cmd;
    logic           pop;
    // back status: memory clear still running
    logic           clearing;

    tmre_front #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_opcode      (i_opcode),
        .i_plane       (i_plane),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_tile_number (i_tile_number),
        .i_palette     (i_palette),
        .i_flip_h      (i_flip_h),
        .i_flip_v      (i_flip_v),
        .i_clearing    (clearing),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    tmre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tmre_back #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_strobe       (o_result_strobe),
        .o_read_tile    (o_read_tile),
        .o_read_palette (o_read_palette)
    );

endmodule

`default_nettype wire

/* sim/tile_map_rect_engine_test.sv */
`timescale 1ns / 1ps

module tile_map_rect_engine_test;

    // Worst case is every command a full-plane recolor plus sender gaps and the
    // clearing pass; this limit is several times that.
    localparam int CYCLE_LIMIT   = 3_000_000;
    // Quiet window after the last owed result; any stray result lands here.
    localparam int DRAIN_CYCLES  = 3200;
    localparam int RANDOM_ITEMS  = 555;
    localparam int QUIET_FIRST   = 150;   // random items sent back to back
    localparam int QUIET_LAST    = 299;
    localparam int HOLD_OFF_ITEM = 300;   // sender waits for every readback here
    localparam int REPORT_MAX    = 10;
    localparam bit TYPED         = 1'b1;  // row carries its own expected readback
    localparam bit PREDICTED     = 1'b0;  // row is checked against the shadow map

    typedef struct packed {
        tmre_pkg::t_op op;
        logic          plane;
        logic [4:0]    x;
        logic [4:0]    y;
        logic [5:0]    w;
        logic [5:0]    h;
        logic [8:0]    tile;
        logic [3:0]    pal;
        logic          fh;
        logic          fv;
    } t_map_cmd;

    typedef struct packed {
        logic [8:0] tile;
        logic [3:0] pal;
    } t_readback;

    typedef struct packed {
        tmre_pkg::t_op op;
        logic          plane;
        logic [4:0]    x;
        logic [4:0]    y;
        logic [5:0]    w;
        logic [5:0]    h;
        logic [8:0]    tile;
        logic [3:0]    pal;
        logic          fh;
        logic          fv;
        logic          typed;
        logic [8:0]    want_tile;
        logic [3:0]    want_pal;
    } t_dir_row;

    localparam int N_DIRECTED = 25;

    // Directed sequence. Columns: op, plane, x, y, width, height, tile, palette,
    // hflip, vflip, expectation kind, expected tile, expected palette.
    t_dir_row directed_rows [N_DIRECTED] = '{
        // maps come out of reset all zero
        '{tmre_pkg::OP_READ,    0,  0,  0,  0,  0, 'h000,  0, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    1, 31, 31,  0,  0, 'h000,  0, 0, 0, TYPED, 'h000,  0},
        // single entry at the far corner, every data bit set
        '{tmre_pkg::OP_WRITE,   0, 31, 31,  0,  0, 'h1FF, 15, 1, 1, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0, 31, 31,  0,  0, 'h000,  0, 0, 0, TYPED, 'h1FF, 15},
        // the other plane is untouched
        '{tmre_pkg::OP_READ,    1, 31, 31,  0,  0, 'h000,  0, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_WRITE,   1,  0,  0,  0,  0, 'h155, 10, 0, 1, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    1,  0,  0,  0,  0, 'h000,  0, 0, 0, TYPED, 'h155, 10},
        // fill wrapping past both edges, flips on the command are ignored
        '{tmre_pkg::OP_FILL,    0, 30, 30,  4,  4, 'h0AA,  5, 1, 1, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0,  1,  1,  0,  0, 'h000,  0, 0, 0, TYPED, 'h0AA,  5},
        '{tmre_pkg::OP_READ,    0, 31, 31,  0,  0, 'h000,  0, 0, 0, TYPED, 'h0AA,  5},
        // recolor wrapping in x keeps the tile number
        '{tmre_pkg::OP_RECOLOR, 0, 31,  0,  3,  2, 'h1FF,  9, 1, 1, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0,  1,  1,  0,  0, 'h000,  0, 0, 0, TYPED, 'h0AA,  9},
        '{tmre_pkg::OP_READ,    0, 30,  1,  0,  0, 'h000,  0, 0, 0, TYPED, 'h0AA,  5},
        // zero width writes nothing
        '{tmre_pkg::OP_FILL,    0,  5,  5,  0,  5, 'h1FF, 15, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0,  5,  5,  0,  0, 'h000,  0, 0, 0, TYPED, 'h000,  0},
        // oversized rectangles saturate to the whole plane
        '{tmre_pkg::OP_FILL,    1,  7,  3, 63, 63, 'h123,  3, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    1,  6,  2,  0,  0, 'h000,  0, 0, 0, TYPED, 'h123,  3},
        '{tmre_pkg::OP_RECOLOR, 1,  0,  0, 32, 40, 'h000, 12, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    1, 17, 29,  0,  0, 'h000,  0, 0, 0, TYPED, 'h123, 12},
        // recolor over an entry with flips
        '{tmre_pkg::OP_WRITE,   0, 10, 10,  0,  0, 'h100,  1, 1, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_RECOLOR, 0, 10, 10,  1,  1, 'h000, 15, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0, 10, 10,  0,  0, 'h000,  0, 0, 0, TYPED, 'h100, 15},
        // zero height recolor, then a full row just past the width limit
        '{tmre_pkg::OP_RECOLOR, 0,  2,  2,  7,  0, 'h000,  3, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_FILL,    0,  0, 20, 33,  1, 'h1FF,  0, 0, 0, TYPED, 'h000,  0},
        '{tmre_pkg::OP_READ,    0, 31, 20,  0,  0, 'h000,  0, 0, 0, PREDICTED, 'h000, 0}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic [1:0] i_opcode        = '0;
    logic       i_plane         = 1'b0;
    logic [4:0] i_pos_x         = '0;
    logic [4:0] i_pos_y         = '0;
    logic [5:0] i_rect_width    = '0;
    logic [5:0] i_rect_height   = '0;
    logic [8:0] i_tile_number   = '0;
    logic [3:0] i_palette       = '0;
    logic       i_flip_h        = 1'b0;
    logic       i_flip_v        = 1'b0;
    logic       busy;
    logic       o_result_strobe;
    logic [8:0] o_read_tile;
    logic [3:0] o_read_palette;

    // Shadow copy of both planes, indexed {plane, row, column}
    logic [15:0] map_shadow [0:2047];
    // Readbacks still owed by the block, oldest first
    t_readback   due_readbacks [$];
    int          fail_count  = 0;
    int          cycle_count = 0;

    tile_map_rect_engine DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_plane         (i_plane),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_tile_number   (i_tile_number),
        .i_palette       (i_palette),
        .i_flip_h        (i_flip_h),
        .i_flip_v        (i_flip_v),
        .o_result_strobe (o_result_strobe),
        .o_read_tile     (o_read_tile),
        .o_read_palette  (o_read_palette)
    );

    always #10 i_clk = ~i_clk;

    // Applies one command to the shadow map and returns the readback it owes.
    // Non-read commands owe an all-zero readback.
    function automatic t_readback run_map_command(t_map_cmd cmd);
        t_readback   rb;
        int unsigned cols;
        int unsigned rows;
        int unsigned r;
        int unsigned c;
        logic [4:0]  cx;
        logic [4:0]  cy;
        logic [10:0] idx;
        logic [15:0] entry;
        rb    = '0;
        cols  = (cmd.w > 32) ? 32 : cmd.w;
        rows  = (cmd.h > 32) ? 32 : cmd.h;
        idx   = {cmd.plane, cmd.y, cmd.x};
        case (cmd.op)
            tmre_pkg::OP_WRITE: begin
                map_shadow[idx] = {cmd.fh, cmd.fv, 1'b0, cmd.pal, cmd.tile};
            end
            tmre_pkg::OP_READ: begin
                entry   = map_shadow[idx];
                rb.tile = entry[tmre_pkg::TILE_W-1:0];
                rb.pal  = entry[tmre_pkg::PAL_LSB +: tmre_pkg::PAL_W];
            end
            default: begin
                for (r = 0; r < rows; r++) begin
                    for (c = 0; c < cols; c++) begin
                        // 5-bit sums wrap around the map edges
                        cx  = cmd.x + 5'(c);
                        cy  = cmd.y + 5'(r);
                        idx = {cmd.plane, cy, cx};
                        if (cmd.op == tmre_pkg::OP_FILL) begin
                            map_shadow[idx] = {3'b000, cmd.pal, cmd.tile};
                        end else begin
                            map_shadow[idx] =
                                (map_shadow[idx] & tmre_pkg::PAL_KEEP_MASK) |
                                {3'b000, cmd.pal, 9'h000};
                        end
                    end
                end
            end
        endcase
        return rb;
    endfunction

    // Random command. Reads dominate so the map content gets observed; most
    // rectangles are small, about one in ten spans up to the full 6-bit range.
    function automatic t_map_cmd random_map_command();
        t_map_cmd    cmd;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            cmd.op = tmre_pkg::OP_READ;
        end else if (pick < 65) begin
            cmd.op = tmre_pkg::OP_WRITE;
        end else if (pick < 85) begin
            cmd.op = tmre_pkg::OP_FILL;
        end else begin
            cmd.op = tmre_pkg::OP_RECOLOR;
        end
        cmd.plane = 1'($urandom_range(1));
        // half the time stay in one corner so reads hit recently written entries
        if ($urandom_range(1) == 0) begin
            cmd.x = 5'($urandom_range(7));
            cmd.y = 5'($urandom_range(7));
        end else begin
            cmd.x = 5'($urandom_range(31));
            cmd.y = 5'($urandom_range(31));
        end
        cmd.w    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(6));
        cmd.h    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(6));
        cmd.tile = 9'($urandom_range(511));
        cmd.pal  = 4'($urandom_range(15));
        cmd.fh   = 1'($urandom_range(1));
        cmd.fv   = 1'($urandom_range(1));
        return cmd;
    endfunction

    // Presents one command and holds it until the transfer. Returns at the
    // edge of the transfer; start is left high so the next command can
    // follow back to back.
    task automatic send_map_command(input t_map_cmd cmd, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < 31) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_opcode      <= cmd.op;
        i_plane       <= cmd.plane;
        i_pos_x       <= cmd.x;
        i_pos_y       <= cmd.y;
        i_rect_width  <= cmd.w;
        i_rect_height <= cmd.h;
        i_tile_number <= cmd.tile;
        i_palette     <= cmd.pal;
        i_flip_h      <= cmd.fh;
        i_flip_v      <= cmd.fv;
        start         <= 1'b1;
        // busy is sampled before this edge's updates land
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender stops and waits for every owed readback to come back
    task automatic hold_off_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (due_readbacks.size() != 0);
    endtask

    // Result checker: every strobe must match the oldest owed readback
    always @(posedge i_clk) begin
        t_readback want;
        if (i_rst_n && o_result_strobe === 1'b1) begin
            if (due_readbacks.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected result: tile %h palette %h",
                             o_read_tile, o_read_palette);
                end
            end else begin
                want = due_readbacks.pop_front();
                if (o_read_tile !== want.tile) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("read_tile mismatch: expected %h got %h",
                                 want.tile, o_read_tile);
                    end
                end
                if (o_read_palette !== want.pal) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("read_palette mismatch: expected %h got %h",
                                 want.pal, o_read_palette);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_map_cmd  cmd;
        t_readback rb;
        t_dir_row  row;

        foreach (map_shadow[i]) begin
            map_shadow[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass keeps busy high; the first transfer simply waits.

        // Directed part: typed rows push their own expectation, but still go
        // through the shadow map so later predicted rows see the right state.
        foreach (directed_rows[i]) begin
            row       = directed_rows[i];
            cmd.op    = row.op;
            cmd.plane = row.plane;
            cmd.x     = row.x;
            cmd.y     = row.y;
            cmd.w     = row.w;
            cmd.h     = row.h;
            cmd.tile  = row.tile;
            cmd.pal   = row.pal;
            cmd.fh    = row.fh;
            cmd.fv    = row.fv;
            send_map_command(cmd, 1'b1);
            rb = run_map_command(cmd);
            if (row.typed) begin
                rb.tile = row.want_tile;
                rb.pal  = row.want_pal;
            end
            due_readbacks.push_back(rb);
        end

        hold_off_until_drained();

        // Random part, with one back-to-back stretch and one full hold-off
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_OFF_ITEM) begin
                hold_off_until_drained();
            end
            cmd = random_map_command();
            send_map_command(cmd, !(n >= QUIET_FIRST && n <= QUIET_LAST));
            due_readbacks.push_back(run_map_command(cmd));
        end
        start <= 1'b0;

        while (due_readbacks.size() != 0) @(posedge i_clk);
        // Any result showing up now is a stray and gets flagged by the checker
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && due_readbacks.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
